>>> rtl/core/ccbe_pkg.sv
// shared types, constants and helpers for the clipped colour-key blitter
`default_nettype none

package ccbe_pkg;

  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 160;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned PaddrW   = 5;

  localparam logic [12:0] MaxSide = 13'd4096;

  // register reset values
  localparam logic [12:0] DstWidthRst  = 13'd640;
  localparam logic [12:0] DstHeightRst = 13'd480;
  localparam logic [12:0] SrcStrideRst = 13'd640;
  localparam logic [7:0]  AlphaRst     = 8'd255;

  typedef enum logic [2:0] {
    REG_DST_WIDTH   = 3'd0,
    REG_DST_HEIGHT  = 3'd1,
    REG_SRC_STRIDE  = 3'd2,
    REG_COLOR_KEY   = 3'd3,
    REG_FILL_COLOR  = 3'd4,
    REG_BLEND_ALPHA = 3'd5,
    REG_BLEND_MODE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [12:0]        src_w;
    logic [12:0]        src_h;
    logic signed [12:0] dst_x;
    logic signed [12:0] dst_y;
  } cmd_req_t;

  typedef struct packed {
    logic             rejected;
    logic             arm;
    logic [12:0]      clip_w;
    logic [12:0]      clip_h;
    logic [AddrW-1:0] src_start;
    logic [AddrW-1:0] dst_start;
  } cmd_res_t;

  // exact floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ccbe_clip.sv
// rectangle rejection, edge clipping and start address computation
`default_nettype none

module ccbe_clip (
  input  ccbe_pkg::cmd_req_t cmd_i,
  input  logic [12:0]        dst_width_i,
  input  logic [12:0]        dst_height_i,
  input  logic [12:0]        src_stride_i,
  output ccbe_pkg::cmd_res_t res_o
);

  logic signed [14:0] dx, dy, w, h, wdim, hdim;
  logic signed [14:0] dxc, dyc, wc, hc, wf, hf;
  logic [12:0]        sx, sy, cw, ch;
  logic [25:0]        src_prod, dst_prod;
  logic               reject;

  always_comb begin
    dx   = {{2{cmd_i.dst_x[12]}}, cmd_i.dst_x};
    dy   = {{2{cmd_i.dst_y[12]}}, cmd_i.dst_y};
    w    = {2'b00, cmd_i.src_w};
    h    = {2'b00, cmd_i.src_h};
    wdim = {2'b00, dst_width_i};
    hdim = {2'b00, dst_height_i};

    reject = (dx >= wdim) || (dy >= hdim) || (dx + w <= 15'sd0) || (dy + h <= 15'sd0);

    // left and top edges: shift the source origin by the overhang
    dxc = dx[14] ? 15'sd0 : dx;
    dyc = dy[14] ? 15'sd0 : dy;
    wc  = dx[14] ? w + dx : w;
    hc  = dy[14] ? h + dy : h;
    sx  = dx[14] ? {1'b0, cmd_i.src_x} - cmd_i.dst_x[12:0] : {1'b0, cmd_i.src_x};
    sy  = dy[14] ? {1'b0, cmd_i.src_y} - cmd_i.dst_y[12:0] : {1'b0, cmd_i.src_y};

    // right and bottom edges
    wf = (dxc + wc > wdim) ? wdim - dxc : wc;
    hf = (dyc + hc > hdim) ? hdim - dyc : hc;

    cw = (wf > $signed({2'b00, ccbe_pkg::MaxSide})) ? ccbe_pkg::MaxSide : wf[12:0];
    ch = (hf > $signed({2'b00, ccbe_pkg::MaxSide})) ? ccbe_pkg::MaxSide : hf[12:0];

    src_prod = sy * src_stride_i;
    dst_prod = dyc[12:0] * dst_width_i;

    res_o = '0;
    res_o.rejected = reject;
    if (!reject) begin
      res_o.clip_w    = cw;
      res_o.clip_h    = ch;
      res_o.src_start = src_prod[23:0] + {11'd0, sx};
      res_o.dst_start = dst_prod[23:0] + {11'd0, dxc[12:0]};
      res_o.arm       = (cw != 13'd0) && (ch != 13'd0);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ccbe_blend.sv
// per-channel alpha blend of a source and a destination pixel
`default_nettype none

module ccbe_blend (
  input  logic [31:0] src_pixel_i,
  input  logic [31:0] dst_pixel_i,
  input  logic [7:0]  alpha_i,
  output logic [31:0] pixel_o
);

  logic [7:0]  inv_alpha;
  logic [15:0] sprod, dprod;
  logic [8:0]  chsum;

  always_comb begin
    inv_alpha = 8'd255 - alpha_i;
    pixel_o   = '0;
    for (int i = 0; i < 3; i++) begin
      sprod = src_pixel_i[8*i +: 8] * alpha_i;
      dprod = dst_pixel_i[8*i +: 8] * inv_alpha;
      // both terms together never pass 255
      chsum = {1'b0, ccbe_pkg::div255(sprod)} + {1'b0, ccbe_pkg::div255(dprod)};
      pixel_o[8*i +: 8] = chsum[7:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/clipped_colorkey_blit_engine.sv
// clipped colour-key blitter: command clipping and per-pixel key, fill and blend
//
//  port group   direction  contents
//  s_axis_*     in         command or pixel pair request, tuser selects which
//  m_axis_*     out        one result per request, tlast on the final pixel
//  apb          in/out     seven configuration registers at byte address 4*i
//
// one request per cycle sustained while m_axis_tready stays high
// the input register and the result register are the only stages, so a request
// is taken while a finished result still waits for m_axis_tready
// reset clears the scan state and loads the register defaults; no clearing pass
// a stalled result holds the pipe: only one further request is held at the input
`default_nettype none

module clipped_colorkey_blit_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_x[11:0] src_y[23:12] src_w[36:24] src_h[49:37] dst_x[62:50] dst_y[75:63]
  // src_pixel[107:76] dst_pixel[139:108], zero pad above
  input  logic [ccbe_pkg::InDataW-1:0]      s_axis_tdata,
  // kind: 0 command, 1 pixel pair
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rejected[0] clip_w[13:1] clip_h[26:14] src_start[50:27] dst_start[74:51]
  // write_enable[75] out_pixel[107:76] dst_address[131:108] src_address[155:132]
  output logic [ccbe_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ccbe_pkg::PaddrW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic [12:0] dst_width_q, dst_height_q, src_stride_q;
  logic [31:0] color_key_q, fill_color_q;
  logic [7:0]  blend_alpha_q;
  logic        blend_mode_q;
  logic        cfg_wr;
  ccbe_pkg::reg_idx_e cfg_idx;

  // pipe registers
  logic                          in_valid_q, in_valid_d;
  logic                          in_kind_q;
  logic [ccbe_pkg::InDataW-1:0]  in_data_q;
  logic                          out_valid_q, out_valid_d;
  logic [ccbe_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;
  logic                          advance, in_take;

  // scan state
  logic        active_q, active_d;
  logic [11:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [12:0] run_w_q, run_w_d, run_h_q, run_h_d;
  logic [ccbe_pkg::AddrW-1:0] src_base_q, src_base_d, dst_base_q, dst_base_d;

  ccbe_pkg::cmd_req_t cmd;
  ccbe_pkg::cmd_res_t cmd_res;
  logic [31:0] src_pixel, dst_pixel, blend_pixel, pix_out;
  logic [24:0] dst_row_off, src_row_off;
  logic [ccbe_pkg::AddrW-1:0] dst_addr, src_addr;
  logic        col_end, row_end, fin, opaque;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ccbe_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      ccbe_pkg::REG_DST_WIDTH:   prdata = {19'd0, dst_width_q};
      ccbe_pkg::REG_DST_HEIGHT:  prdata = {19'd0, dst_height_q};
      ccbe_pkg::REG_SRC_STRIDE:  prdata = {19'd0, src_stride_q};
      ccbe_pkg::REG_COLOR_KEY:   prdata = color_key_q;
      ccbe_pkg::REG_FILL_COLOR:  prdata = fill_color_q;
      ccbe_pkg::REG_BLEND_ALPHA: prdata = {24'd0, blend_alpha_q};
      ccbe_pkg::REG_BLEND_MODE:  prdata = {31'd0, blend_mode_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_width_q   <= ccbe_pkg::DstWidthRst;
      dst_height_q  <= ccbe_pkg::DstHeightRst;
      src_stride_q  <= ccbe_pkg::SrcStrideRst;
      color_key_q   <= '0;
      fill_color_q  <= '0;
      blend_alpha_q <= ccbe_pkg::AlphaRst;
      blend_mode_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ccbe_pkg::REG_DST_WIDTH:   dst_width_q   <= pwdata[12:0];
        ccbe_pkg::REG_DST_HEIGHT:  dst_height_q  <= pwdata[12:0];
        ccbe_pkg::REG_SRC_STRIDE:  src_stride_q  <= pwdata[12:0];
        ccbe_pkg::REG_COLOR_KEY:   color_key_q   <= pwdata;
        ccbe_pkg::REG_FILL_COLOR:  fill_color_q  <= pwdata;
        ccbe_pkg::REG_BLEND_ALPHA: blend_alpha_q <= pwdata[7:0];
        ccbe_pkg::REG_BLEND_MODE:  blend_mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // unpack the held request
  always_comb begin
    cmd.src_x = in_data_q[11:0];
    cmd.src_y = in_data_q[23:12];
    cmd.src_w = in_data_q[36:24];
    cmd.src_h = in_data_q[49:37];
    cmd.dst_x = in_data_q[62:50];
    cmd.dst_y = in_data_q[75:63];
    src_pixel = in_data_q[107:76];
    dst_pixel = in_data_q[139:108];
  end

  ccbe_clip u_clip (
    .cmd_i        (cmd),
    .dst_width_i  (dst_width_q),
    .dst_height_i (dst_height_q),
    .src_stride_i (src_stride_q),
    .res_o        (cmd_res)
  );

  ccbe_blend u_blend (
    .src_pixel_i (src_pixel),
    .dst_pixel_i (dst_pixel),
    .alpha_i     (blend_alpha_q),
    .pixel_o     (blend_pixel)
  );

  // pixel path
  always_comb begin
    col_end     = ({1'b0, cur_col_q} + 13'd1) >= run_w_q;
    row_end     = ({1'b0, cur_row_q} + 13'd1) >= run_h_q;
    fin         = col_end && row_end;
    opaque      = src_pixel != color_key_q;
    dst_row_off = cur_row_q * dst_width_q;
    src_row_off = cur_row_q * src_stride_q;
    dst_addr    = dst_base_q + dst_row_off[23:0] + {12'd0, cur_col_q};
    src_addr    = src_base_q + src_row_off[23:0] + {12'd0, cur_col_q};
    if (!opaque) begin
      pix_out = '0;
    end else if (blend_mode_q) begin
      pix_out = {8'd0, blend_pixel[23:0]};
    end else begin
      pix_out = fill_color_q;
    end
  end

  // next state and result
  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    active_d    = active_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    run_w_d     = run_w_q;
    run_h_d     = run_h_q;
    src_base_d  = src_base_q;
    dst_base_d  = dst_base_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_last_d  = 1'b0;
      if (!in_kind_q) begin
        out_data_d[74:0] = {cmd_res.dst_start, cmd_res.src_start, cmd_res.clip_h,
                            cmd_res.clip_w, cmd_res.rejected};
        active_d = cmd_res.arm;
        if (!cmd_res.rejected) begin
          run_w_d    = cmd_res.clip_w;
          run_h_d    = cmd_res.clip_h;
          src_base_d = cmd_res.src_start;
          dst_base_d = cmd_res.dst_start;
          cur_col_d  = '0;
          cur_row_d  = '0;
        end
      end else if (active_q) begin
        out_data_d[155:75] = {src_addr, dst_addr, pix_out, opaque};
        out_last_d         = fin;
        if (fin) begin
          active_d  = 1'b0;
          cur_col_d = '0;
          cur_row_d = '0;
        end else if (col_end) begin
          cur_col_d = '0;
          cur_row_d = cur_row_q + 12'd1;
        end else begin
          cur_col_d = cur_col_q + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      run_w_q     <= '0;
      run_h_q     <= '0;
      src_base_q  <= '0;
      dst_base_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      run_w_q     <= run_w_d;
      run_h_q     <= run_h_d;
      src_base_q  <= src_base_d;
      dst_base_q  <= dst_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_kind_q <= s_axis_tuser;
    end
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // an armed scan always has a non-empty area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (run_w_q != 13'd0) && (run_h_q != 13'd0))
    else $error("active scan with empty area");

  // scan position stays inside the clipped area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ({1'b0, cur_col_q} < run_w_q) && ({1'b0, cur_row_q} < run_h_q))
    else $error("scan position outside clipped area");

  // the final pixel ends the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_kind_q && active_q && fin) |=> !active_q)
    else $error("scan still active after final pixel");

  // a held request is never dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_data_q))
    else $error("held request lost during stall");

  // a rejected command carries no size and no pixel write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[0]) |-> (out_data_q[155:1] == '0) && !out_last_q)
    else $error("rejected result with non-zero fields");

endmodule

`default_nettype wire
